[design/bba_pkg.sv]
`default_nettype none

package bba_pkg;

   // Map word width used by the scan unit.
   localparam int WORD_W     = 32;
   localparam int WORD_LOG   = 5;

   // Fixed transaction field widths.
   localparam int START_W    = 10;
   localparam int COUNT_W    = 11;

   // Default number of storage blocks.
   localparam int BLOCKS_DEF = 1024;

   typedef logic [WORD_W-1:0] word_type;

   localparam word_type WORD_ONES = {WORD_W{1'b1}};

   typedef enum logic [1:0] {
      OP_FIND  = 2'd0,
      OP_MARK  = 2'd1,
      OP_FREE  = 2'd2,
      OP_COUNT = 2'd3
   } op_type;

   // Number of consecutive ones starting at bit 0.
   function automatic logic [WORD_LOG:0] trail_ones(word_type w);
      logic [WORD_LOG:0] n;
      n = (WORD_LOG+1)'(WORD_W);
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!w[i]) begin
            n = (WORD_LOG+1)'(i);
         end
      end
      return n;
   endfunction

   // Number of consecutive ones ending at the top bit.
   function automatic logic [WORD_LOG:0] lead_ones(word_type w);
      logic [WORD_LOG:0] n;
      n = (WORD_LOG+1)'(WORD_W);
      for (int i = 0; i < WORD_W; i++) begin
         if (!w[i]) begin
            n = (WORD_LOG+1)'(WORD_W - 1 - i);
         end
      end
      return n;
   endfunction

   // Index of the lowest set bit; zero when no bit is set.
   function automatic logic [WORD_LOG-1:0] low_index(word_type w);
      logic [WORD_LOG-1:0] n;
      n = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (w[i]) begin
            n = WORD_LOG'(i);
         end
      end
      return n;
   endfunction

   // Marks every bit position p where bits p .. p+n-1 are all set.
   // The run length is built from power-of-two partial runs.
   function automatic word_type run_starts(word_type f, logic [WORD_LOG:0] n);
      word_type          q [WORD_LOG+1];
      word_type          s;
      logic [WORD_LOG:0] off;
      q[0] = f;
      for (int k = 1; k <= WORD_LOG; k++) begin
         q[k] = q[k-1] & (q[k-1] >> (1 << (k - 1)));
      end
      s   = WORD_ONES;
      off = '0;
      for (int k = 0; k <= WORD_LOG; k++) begin
         if (n[k]) begin
            s   = s & (q[k] >> off);
            off = off + (WORD_LOG+1)'(1 << k);
         end
      end
      return s;
   endfunction

   // Population count of one map word as an adder tree.
   function automatic logic [WORD_LOG:0] pop_count(word_type w);
      logic [1:0] l1 [16];
      logic [2:0] l2 [8];
      logic [3:0] l3 [4];
      logic [4:0] l4 [2];
      for (int i = 0; i < 16; i++) begin
         l1[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
      end
      for (int i = 0; i < 8; i++) begin
         l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
      end
      for (int i = 0; i < 4; i++) begin
         l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
      end
      for (int i = 0; i < 2; i++) begin
         l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
      end
      return {1'b0, l4[0]} + {1'b0, l4[1]};
   endfunction

endpackage

`default_nettype wire

[design/bitmap_block_allocator.sv]
`default_nettype none

// Bitmap block allocator. One used bit per storage block is kept in a map
// memory of 32-bit words. The req_ channel carries one transaction: an op,
// a start block and a block count. find_run searches upward from the start
// block for the first run of free blocks of the requested length, mark_range
// and free_range set or clear the used bits of a range (clipped at the last
// block), and count_free totals the free blocks. Every request transaction
// produces exactly one rsp_ transaction.
// A single word-wide scan unit walks the map one word per cycle, behind a
// registered read port. A transaction visits up to BLOCKS/32 map words
// (rounded up); once its result is loaded into the output register the
// block returns to idle and can take the next request. For all ops but
// count_free, a zero count or a start past the end skips the scan.
// After reset the map memory is swept to all free, one word per cycle;
// req_stall stays high during that sweep and while a transaction is in
// progress. The result is held in an output register, so a new request
// is accepted while an earlier result waits on rsp_stall; a finished
// transaction waits for that register before it completes.

module bitmap_block_allocator #(
   parameter int BLOCKS = bba_pkg::BLOCKS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire  [1:0]                    req_op,
   input  wire  [bba_pkg::START_W-1:0]   req_start_block,
   input  wire  [bba_pkg::COUNT_W-1:0]   req_block_count,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic                          rsp_found,
   output logic [bba_pkg::START_W-1:0]   rsp_run_start,
   output logic [bba_pkg::COUNT_W-1:0]   rsp_free_total
);

   localparam int WORD_W    = bba_pkg::WORD_W;
   localparam int WORD_LOG  = bba_pkg::WORD_LOG;
   localparam int START_W   = bba_pkg::START_W;
   localparam int COUNT_W   = bba_pkg::COUNT_W;
   localparam int WORDS     = (BLOCKS + WORD_W - 1) / WORD_W;
   localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CNT_W     = $clog2(BLOCKS + 1);
   // Working width for block indexes and run lengths, with a spare bit so
   // that a run length plus a word never wraps.
   localparam int LW        = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;
   localparam int TAIL_BITS = BLOCKS - (WORDS - 1) * WORD_W;

   localparam bba_pkg::word_type ALL_ONES  = bba_pkg::WORD_ONES;
   localparam bba_pkg::word_type TAIL_MASK = ALL_ONES >> (WORD_W - TAIL_BITS);
   localparam logic [AW-1:0]     LAST_WORD = AW'(WORDS - 1);
   localparam logic [LW-1:0]     BLK_NUM   = LW'(BLOCKS);
   localparam logic [LW-1:0]     BLK_LAST  = LW'(BLOCKS - 1);
   localparam logic [LW-1:0]     WORD_LEN  = LW'(WORD_W);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Sequencer state and transaction context.
   state_type               state_ff,     state_in;
   logic [AW-1:0]           clr_ff,       clr_in;
   bba_pkg::op_type         op_ff,        op_in;
   logic [WORD_LOG-1:0]     lo_ff,        lo_in;
   logic [WORD_LOG-1:0]     hi_ff,        hi_in;
   logic [AW-1:0]           fw_ff,        fw_in;
   logic [AW-1:0]           lw_ff,        lw_in;
   logic [AW-1:0]           stop_ff,      stop_in;
   logic [LW-1:0]           len_ff,       len_in;

   // Read issue and processing stage of the scan unit.
   logic [AW-1:0]           iss_ff,       iss_in;
   logic                    iss_act_ff,   iss_act_in;
   logic                    pv_ff,        pv_in;
   logic [AW-1:0]           pw_ff,        pw_in;

   // Scan accumulators.
   logic [LW-1:0]           run_ff,       run_in;
   logic [LW-1:0]           begin_ff,     begin_in;
   logic [CNT_W-1:0]        acc_ff,       acc_in;

   // Finished result and output register.
   logic                    res_found_ff, res_found_in;
   logic [START_W-1:0]      res_start_ff, res_start_in;
   logic [COUNT_W-1:0]      res_total_ff, res_total_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [START_W-1:0]      rsp_start_ff, rsp_start_in;
   logic [COUNT_W-1:0]      rsp_total_ff, rsp_total_in;

   // Map memory.
   bba_pkg::word_type       map_ff [WORDS];
   bba_pkg::word_type       rdata_ff;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   bba_pkg::word_type       wr_data;

   // Request decode.
   logic [LW-1:0]           first_w;
   logic [LW-1:0]           count_w;
   logic [LW-1:0]           end_w;
   logic [LW-1:0]           lastb_w;
   logic                    range_ok;
   bba_pkg::op_type         req_op_t;

   // Word processing.
   bba_pkg::word_type       lo_mask;
   bba_pkg::word_type       rng_mask;
   bba_pkg::word_type       free_bits;
   bba_pkg::word_type       starts;
   logic [WORD_LOG-1:0]     lo_sel;
   logic [WORD_LOG-1:0]     hi_sel;
   logic [WORD_LOG:0]       t_ones;
   logic [WORD_LOG:0]       l_ones;
   logic [WORD_LOG:0]       pop;
   logic [WORD_LOG-1:0]     s_idx;
   logic [LW-1:0]           base;
   logic                    hit_carry;
   logic                    hit_inner;
   logic                    last_proc;

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_run_start  = rsp_start_ff;
   assign rsp_free_total = rsp_total_ff;

   // Request decode: the clipped range [first_w, lastb_w].
   assign req_op_t = bba_pkg::op_type'(req_op);
   assign first_w  = LW'(req_start_block);
   assign count_w  = LW'(req_block_count);
   assign end_w    = first_w + count_w - LW'(1);
   assign lastb_w  = (end_w > BLK_LAST) ? BLK_LAST : end_w;
   assign range_ok = (first_w < BLK_NUM) && (count_w != '0);

   // Per-word view of the map word that came back from memory.
   always_comb begin
      lo_sel    = (pw_ff == fw_ff) ? lo_ff : '0;
      hi_sel    = (pw_ff == lw_ff) ? hi_ff : WORD_LOG'(WORD_W - 1);
      lo_mask   = ALL_ONES << lo_sel;
      rng_mask  = lo_mask & (ALL_ONES >> (WORD_LOG'(WORD_W - 1) - hi_sel));
      free_bits = ~rdata_ff & lo_mask & ((pw_ff == LAST_WORD) ? TAIL_MASK : ALL_ONES);
      pop       = bba_pkg::pop_count(free_bits);
      t_ones    = bba_pkg::trail_ones(free_bits);
      l_ones    = bba_pkg::lead_ones(free_bits);
      starts    = (len_ff <= WORD_LEN) ?
                  bba_pkg::run_starts(free_bits, len_ff[WORD_LOG:0]) : '0;
      s_idx     = bba_pkg::low_index(starts);
      base      = LW'(pw_ff) << WORD_LOG;
      // A run carried in from lower words completes in this word.
      hit_carry = (run_ff != '0) && ((run_ff + LW'(t_ones)) >= len_ff);
      // A run that lies wholly inside this word.
      hit_inner = (starts != '0);
      last_proc = (pw_ff == stop_ff);
   end

   // Memory port control.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pw_ff;
      wr_data = (op_ff == bba_pkg::OP_MARK) ? (rdata_ff | rng_mask) :
                                              (rdata_ff & ~rng_mask);
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if ((state_ff == ST_SCAN) && pv_ff &&
                   ((op_ff == bba_pkg::OP_MARK) || (op_ff == bba_pkg::OP_FREE))) begin
         wr_en = 1'b1;
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      fw_in        = fw_ff;
      lw_in        = lw_ff;
      stop_in      = stop_ff;
      len_in       = len_ff;
      iss_in       = iss_ff;
      iss_act_in   = iss_act_ff;
      pv_in        = 1'b0;
      pw_in        = pw_ff;
      run_in       = run_ff;
      begin_in     = begin_ff;
      acc_in       = acc_ff;
      res_found_in = res_found_ff;
      res_start_in = res_start_ff;
      res_total_in = res_total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_start_in = rsp_start_ff;
      rsp_total_in = rsp_total_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               op_in        = req_op_t;
               len_in       = count_w;
               lo_in        = first_w[WORD_LOG-1:0];
               hi_in        = lastb_w[WORD_LOG-1:0];
               fw_in        = first_w[AW+WORD_LOG-1:WORD_LOG];
               lw_in        = lastb_w[AW+WORD_LOG-1:WORD_LOG];
               run_in       = '0;
               begin_in     = '0;
               acc_in       = '0;
               res_found_in = 1'b0;
               res_start_in = '0;
               res_total_in = '0;
               iss_act_in   = 1'b1;
               state_in     = ST_SCAN;
               case (req_op_t)
                  bba_pkg::OP_FIND: begin
                     iss_in  = first_w[AW+WORD_LOG-1:WORD_LOG];
                     stop_in = LAST_WORD;
                  end
                  bba_pkg::OP_MARK, bba_pkg::OP_FREE: begin
                     iss_in  = first_w[AW+WORD_LOG-1:WORD_LOG];
                     stop_in = lastb_w[AW+WORD_LOG-1:WORD_LOG];
                  end
                  default: begin
                     // count_free walks the whole map with no start mask.
                     iss_in  = '0;
                     stop_in = LAST_WORD;
                     lo_in   = '0;
                     fw_in   = '0;
                  end
               endcase
               if ((req_op_t != bba_pkg::OP_COUNT) && !range_ok) begin
                  iss_act_in = 1'b0;
                  state_in   = ST_DONE;
               end
            end
         end

         ST_SCAN: begin
            // Issue the next map read; its data is processed in the cycle after the read.
            if (iss_act_ff) begin
               pv_in = 1'b1;
               pw_in = iss_ff;
               if (iss_ff == stop_ff) begin
                  iss_act_in = 1'b0;
               end else begin
                  iss_in = iss_ff + AW'(1);
               end
            end
            if (pv_ff) begin
               case (op_ff)
                  bba_pkg::OP_FIND: begin
                     if (hit_carry || hit_inner) begin
                        res_found_in = 1'b1;
                        res_start_in = hit_carry ? START_W'(begin_ff) :
                                                   START_W'(base + LW'(s_idx));
                     end else if (free_bits == ALL_ONES) begin
                        run_in   = run_ff + WORD_LEN;
                        begin_in = (run_ff == '0) ? base : begin_ff;
                     end else begin
                        run_in   = LW'(l_ones);
                        begin_in = base + WORD_LEN - LW'(l_ones);
                     end
                     if (hit_carry || hit_inner || last_proc) begin
                        iss_act_in = 1'b0;
                        pv_in      = 1'b0;
                        state_in   = ST_DONE;
                     end
                  end
                  bba_pkg::OP_COUNT: begin
                     acc_in = acc_ff + CNT_W'(pop);
                     if (last_proc) begin
                        res_total_in = COUNT_W'(acc_ff + CNT_W'(pop));
                        state_in     = ST_DONE;
                     end
                  end
                  default: begin
                     // Range update: the word is written back by the memory port.
                     if (last_proc) begin
                        state_in = ST_DONE;
                     end
                  end
               endcase
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_start_in = res_start_ff;
               rsp_total_in = res_total_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         iss_ff       <= '0;
         iss_act_ff   <= 1'b0;
         pv_ff        <= 1'b0;
         pw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         iss_ff       <= iss_in;
         iss_act_ff   <= iss_act_in;
         pv_ff        <= pv_in;
         pw_ff        <= pw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      fw_ff        <= fw_in;
      lw_ff        <= lw_in;
      stop_ff      <= stop_in;
      len_ff       <= len_in;
      run_ff       <= run_in;
      begin_ff     <= begin_in;
      acc_ff       <= acc_in;
      res_found_ff <= res_found_in;
      res_start_ff <= res_start_in;
      res_total_ff <= res_total_in;
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
      rsp_total_ff <= rsp_total_in;
   end

   // Map memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= map_ff[iss_ff];
   end

endmodule

`default_nettype wire

[tb/sv/tb_bitmap_block_allocator.sv]
`timescale 1ns / 100ps

module tb_bitmap_block_allocator;

   // The map size of the instance under test. The stimulus relies on the
   // default size, where every start block the port can carry is inside the map.
   localparam int BLOCKS       = bba_pkg::BLOCKS_DEF;
   localparam int START_W      = bba_pkg::START_W;
   localparam int COUNT_W      = bba_pkg::COUNT_W;
   localparam int RANDOM_ITEMS = 400;
   // The receiver holds off this long while the sender keeps offering requests.
   localparam int HOLD_CYCLES  = 600;
   // Cycles without any accepted transaction before the run is declared hung.
   // The slowest legal stretch is the long hold plus one full scan.
   localparam int IDLE_LIMIT   = 5000;
   // Cycles to wait after the last result, a few times a full map scan.
   localparam int TAIL_CYCLES  = 150;

   // One response as the block reports it.
   typedef struct packed {
      logic                found;
      logic [START_W-1:0]  run_start;
      logic [COUNT_W-1:0]  free_total;
   } alloc_rsp_type;

   // One row of the directed table. Where has_typed is set, the response is
   // written into the row itself; otherwise it comes from the map model.
   typedef struct packed {
      bba_pkg::op_type     op;
      logic [START_W-1:0]  start;
      logic [COUNT_W-1:0]  count;
      logic                has_typed;
      alloc_rsp_type       typed;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   bba_pkg::op_type     req_op = bba_pkg::OP_FIND;
   logic [START_W-1:0]  req_start_block = '0;
   logic [COUNT_W-1:0]  req_block_count = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_found;
   logic [START_W-1:0]  rsp_run_start;
   logic [COUNT_W-1:0]  rsp_free_total;

   // Model of the used map, one bit per block, 1 meaning used.
   logic [BLOCKS-1:0]   used_bits = '0;
   // Responses predicted for accepted requests, oldest first.
   alloc_rsp_type       predicted_rsp_q [$];

   int                  error_count = 0;
   int                  req_accepted = 0;
   int                  rsp_accepted = 0;
   int                  op_accepted [4] = '{0, 0, 0, 0};
   int                  find_hits = 0;
   int                  idle_cycles = 0;
   // Set by the stimulus to ask the receiver for one long hold-off.
   bit                  rx_hold_req = 1'b0;
   // While set, neither side inserts gaps or stalls.
   bit                  no_idle = 1'b0;

   // The directed table. The rows run in order from the reset state, so the
   // typed responses follow from the map contents left by the rows above.
   stim_row_type directed_rows [24] = '{
      // After reset every block is free.
      '{bba_pkg::OP_COUNT, 10'd0,    11'd0,    1'b1, '{1'b0, 10'd0,    11'd1024}},
      // A single block from block 0 is the first free block.
      '{bba_pkg::OP_FIND,  10'd0,    11'd1,    1'b1, '{1'b1, 10'd0,    11'd0}},
      // A run of length zero is never found.
      '{bba_pkg::OP_FIND,  10'd0,    11'd0,    1'b1, '{1'b0, 10'd0,    11'd0}},
      // The whole map is one run, but only from block 0.
      '{bba_pkg::OP_FIND,  10'd0,    11'd1024, 1'b1, '{1'b1, 10'd0,    11'd0}},
      '{bba_pkg::OP_FIND,  10'd1,    11'd1024, 1'b1, '{1'b0, 10'd0,    11'd0}},
      // A count larger than the map cannot be satisfied.
      '{bba_pkg::OP_FIND,  10'd0,    11'd2047, 1'b1, '{1'b0, 10'd0,    11'd0}},
      '{bba_pkg::OP_FIND,  10'd1023, 11'd1,    1'b1, '{1'b1, 10'd1023, 11'd0}},
      // A zero-length range leaves the map alone.
      '{bba_pkg::OP_MARK,  10'd0,    11'd0,    1'b1, '{1'b0, 10'd0,    11'd0}},
      '{bba_pkg::OP_COUNT, 10'd1023, 11'd2047, 1'b1, '{1'b0, 10'd0,    11'd1024}},
      // A range running past the end is clipped at the last block.
      '{bba_pkg::OP_MARK,  10'd1000, 11'd2047, 1'b1, '{1'b0, 10'd0,    11'd0}},
      '{bba_pkg::OP_COUNT, 10'd0,    11'd0,    1'b1, '{1'b0, 10'd0,    11'd1000}},
      '{bba_pkg::OP_FIND,  10'd1023, 11'd1,    1'b1, '{1'b0, 10'd0,    11'd0}},
      // Fill the map completely.
      '{bba_pkg::OP_MARK,  10'd0,    11'd1024, 1'b1, '{1'b0, 10'd0,    11'd0}},
      '{bba_pkg::OP_COUNT, 10'd0,    11'd0,    1'b1, '{1'b0, 10'd0,    11'd0}},
      '{bba_pkg::OP_FIND,  10'd0,    11'd1,    1'b1, '{1'b0, 10'd0,    11'd0}},
      // Only the last block free: the search must walk the whole map.
      '{bba_pkg::OP_FREE,  10'd1023, 11'd1,    1'b1, '{1'b0, 10'd0,    11'd0}},
      '{bba_pkg::OP_FIND,  10'd0,    11'd1,    1'b1, '{1'b1, 10'd1023, 11'd0}},
      // A hole in the middle, probed with runs that fit and runs that do not.
      '{bba_pkg::OP_FREE,  10'd100,  11'd50,   1'b0, '0},
      '{bba_pkg::OP_FIND,  10'd0,    11'd30,   1'b0, '0},
      '{bba_pkg::OP_FIND,  10'd120,  11'd40,   1'b0, '0},
      // Clear everything with a clipped free.
      '{bba_pkg::OP_FREE,  10'd0,    11'd2047, 1'b1, '{1'b0, 10'd0,    11'd0}},
      '{bba_pkg::OP_COUNT, 10'd0,    11'd0,    1'b1, '{1'b0, 10'd0,    11'd1024}},
      // Alternating bit patterns on the start and count fields.
      '{bba_pkg::OP_MARK,  10'd682,  11'd341,  1'b0, '0},
      '{bba_pkg::OP_FIND,  10'd341,  11'd682,  1'b0, '0}
   };

   bitmap_block_allocator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_start_block (req_start_block),
      .req_block_count (req_block_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_run_start   (rsp_run_start),
      .rsp_free_total  (rsp_free_total)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one request to the map model and returns the response it gives.
   // find_run scans first-fit upward from the start block; mark_range and
   // free_range are clipped at the last block; count_free totals free blocks.
   function automatic alloc_rsp_type map_apply(bba_pkg::op_type op,
                                               logic [START_W-1:0] s,
                                               logic [COUNT_W-1:0] c);
      alloc_rsp_type r;
      int unsigned   run;
      int unsigned   first_i;
      int unsigned   last;
      r       = '0;
      run     = 0;
      first_i = 0;
      case (op)
         bba_pkg::OP_FIND: begin
            if (c != 0) begin
               for (int i = s; i < BLOCKS; i++) begin
                  if (!used_bits[i]) begin
                     if (run == 0) begin
                        first_i = i;
                     end
                     run++;
                     if (run == c) begin
                        r.found     = 1'b1;
                        r.run_start = START_W'(first_i);
                        break;
                     end
                  end else begin
                     run = 0;
                  end
               end
            end
         end
         bba_pkg::OP_MARK, bba_pkg::OP_FREE: begin
            if (c != 0 && s < BLOCKS) begin
               last = s + c;
               if (last > BLOCKS) begin
                  last = BLOCKS;
               end
               for (int i = s; i < last; i++) begin
                  used_bits[i] = (op == bba_pkg::OP_MARK);
               end
            end
         end
         bba_pkg::OP_COUNT: begin
            r.free_total = COUNT_W'(BLOCKS - $countones(used_bits));
         end
         default: ;
      endcase
      return r;
   endfunction

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) begin
         return 0;
      end else if (r < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(15, 60);
   endfunction

   // Run length for allocations and releases: mostly small, rarely huge.
   function automatic logic [COUNT_W-1:0] pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return COUNT_W'($urandom_range(1, 16));
      end else if (r < 90) begin
         return COUNT_W'($urandom_range(17, 64));
      end else if (r < 98) begin
         return COUNT_W'($urandom_range(65, 400));
      end
      return COUNT_W'($urandom_range(1024, 2047));
   endfunction

   // Offers one request and holds it until the block accepts the transaction.
   // The map model is updated at the accepting edge, in this process, so that
   // the next request built here already sees its effect. The predicted (or
   // typed) response is queued, then an optional gap follows with valid low.
   task automatic drive_req(input bba_pkg::op_type op, input logic [START_W-1:0] s,
                            input logic [COUNT_W-1:0] c, input bit has_typed,
                            input alloc_rsp_type typed, output alloc_rsp_type pred);
      int gap;
      req_valid       <= 1'b1;
      req_op          <= op;
      req_start_block <= s;
      req_block_count <= c;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      pred = map_apply(op, s, c);
      predicted_rsp_q.push_back(has_typed ? typed : pred);
      req_accepted++;
      op_accepted[op]++;
      if (op == bba_pkg::OP_FIND && pred.found) begin
         find_hits++;
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Lowers valid and waits until every queued response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_rsp_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Receiver. It stalls in runs of random length, grants a long hold-off on
   // request, and stays open during the no-idle stretch.
   initial begin
      wait (!reset);
      forever begin
         if (rx_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rx_hold_req = 1'b0;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            // Open six times in ten, stalled otherwise.
            rsp_stall <= ($urandom_range(0, 9) >= 6);
            repeat (pick_gap() + 1) @(posedge clock);
         end
      end
   end

   // Response checker. Each accepted response transaction is compared field
   // by field with the oldest prediction.
   always @(posedge clock) begin
      alloc_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_accepted++;
         if (predicted_rsp_q.size() == 0) begin
            $error("response with nothing outstanding: found %0d run_start %0d free_total %0d",
                   rsp_found, rsp_run_start, rsp_free_total);
            error_count++;
         end else begin
            want = predicted_rsp_q.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_found);
               error_count++;
            end
            if (rsp_run_start !== want.run_start) begin
               $error("run_start: expected %0d, got %0d", want.run_start, rsp_run_start);
               error_count++;
            end
            if (rsp_free_total !== want.free_total) begin
               $error("free_total: expected %0d, got %0d", want.free_total, rsp_free_total);
               error_count++;
            end
         end
      end
   end

   // Watchdog. Counts cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("watchdog expired after %0d idle cycles, %0d responses outstanding",
                     IDLE_LIMIT, predicted_rsp_q.size());
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Main stimulus: reset, the directed table, then random traffic.
   initial begin
      alloc_rsp_type       pred;
      logic [START_W-1:0]  s;
      logic [COUNT_W-1:0]  c;
      int                  rand_sent;
      int                  pick;
      bit                  hold_done;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The block is still sweeping its map right after
      // reset, so the first request simply waits on req_stall.
      foreach (directed_rows[i]) begin
         drive_req(directed_rows[i].op, directed_rows[i].start, directed_rows[i].count,
                   directed_rows[i].has_typed, directed_rows[i].typed, pred);
      end

      // Random part. Most traffic is allocations (a first-fit search followed
      // by marking the run it found) and releases of random ranges, so the map
      // fragments and searches have real work to do. The rest is plain
      // searches, totals, and unconstrained noise over the full field ranges.
      rand_sent = 0;
      hold_done = 1'b0;
      while (rand_sent < RANDOM_ITEMS) begin
         if (!hold_done && rand_sent >= 100) begin
            // Back-pressure: the receiver holds off while requests keep
            // coming back to back, filling the result register and the
            // engine so that req_stall rises. Then the sender lets
            // every outstanding response drain before it goes on.
            hold_done   = 1'b1;
            rx_hold_req = 1'b1;
            no_idle     = 1'b1;
            repeat (8) begin
               drive_req(bba_pkg::OP_FIND, START_W'($urandom_range(0, 1023)), pick_len(),
                         1'b0, '0, pred);
               rand_sent++;
            end
            no_idle = 1'b0;
            drain_responses();
         end
         // A stretch where neither side inserts any gap.
         no_idle = (rand_sent >= 250 && rand_sent < 310);

         pick = $urandom_range(0, 99);
         // Keep the map from saturating: when it is mostly used, release.
         if ($countones(used_bits) > BLOCKS * 3 / 4 && pick < 50) begin
            pick = 40;
         end
         if (pick < 35) begin
            c = pick_len();
            s = ($urandom_range(0, 3) == 0) ? START_W'($urandom_range(0, 1023)) : '0;
            drive_req(bba_pkg::OP_FIND, s, c, 1'b0, '0, pred);
            rand_sent++;
            if (pred.found) begin
               drive_req(bba_pkg::OP_MARK, pred.run_start, c, 1'b0, '0, pred);
               rand_sent++;
            end
         end else if (pick < 60) begin
            drive_req(bba_pkg::OP_FREE, START_W'($urandom_range(0, 1023)), pick_len(),
                      1'b0, '0, pred);
            rand_sent++;
         end else if (pick < 75) begin
            drive_req(bba_pkg::OP_FIND, START_W'($urandom_range(0, 1023)), pick_len(),
                      1'b0, '0, pred);
            rand_sent++;
         end else if (pick < 85) begin
            drive_req(bba_pkg::OP_COUNT, START_W'($urandom_range(0, 1023)),
                      COUNT_W'($urandom_range(0, 2047)), 1'b0, '0, pred);
            rand_sent++;
         end else begin
            drive_req(bba_pkg::op_type'($urandom_range(0, 3)),
                      START_W'($urandom_range(0, 1023)),
                      COUNT_W'($urandom_range(0, 2047)), 1'b0, '0, pred);
            rand_sent++;
         end
      end
      no_idle = 1'b0;

      // Wind down: wait for every response, then a tail long enough to
      // catch any spurious late response.
      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d requests: %0d find_run (%0d hits), %0d mark_range, %0d free_range,",
               req_accepted, op_accepted[bba_pkg::OP_FIND], find_hits,
               op_accepted[bba_pkg::OP_MARK], op_accepted[bba_pkg::OP_FREE]);
      $display("%0d count_free; %0d responses checked, one long response hold-off included.",
               op_accepted[bba_pkg::OP_COUNT], rsp_accepted);
      if (error_count == 0 && predicted_rsp_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
